[sv/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 6;

  // Register index codes on the configuration port
  localparam logic RegStartChar = 1'b0;
  localparam logic RegEndChar   = 1'b1;

  localparam logic [ByteW-1:0] StartCharRst = 8'd35;
  localparam logic [ByteW-1:0] EndCharRst   = 8'd13;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StSend = 2'b10
  } dfr_state_e;

endpackage

[sv/dfr_frame_mem.sv]
// ----------------------------------------------------------------------------
// dfr_frame_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dfr_frame_mem #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] waddr_i,
  input  logic [dfr_pkg::ByteW-1:0]       wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] raddr_i,
  output logic [dfr_pkg::ByteW-1:0]       rdata_o
);

  logic [dfr_pkg::ByteW-1:0] mem_q [BUFFER_DEPTH];
  logic [dfr_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/delimited_frame_receiver.sv]
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Collects received bytes into a frame store between a start and an end
// character and plays the stored frame out byte by byte on an end character.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  --------  ---------  --------------------  ----------------------------------
//  rx        in         in_valid_i/in_stall_o  rx_byte_i
//  msg       out        out_valid_o/out_stall_i msg_byte_o, msg_last_o, msg_length_o
//  cfg       in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
//  A start or data byte makes one write into the store.
//  An end byte with n held bytes keeps rx stalled while the frame plays out
//  and while msg is stalled, with one store read per result.
//  Reset clears the fill count and loads start '#' and end CR; the store
//  itself is not cleared, only entries below the fill count are ever read.
//  A stalled msg request holds its bytes in the store's read register.
// ----------------------------------------------------------------------------
module delimited_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // receive channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dfr_pkg::ByteW-1:0]   rx_byte_i,
  // message channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dfr_pkg::ByteW-1:0]   msg_byte_o,
  output logic                        msg_last_o,
  output logic [dfr_pkg::LenW-1:0]    msg_length_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [dfr_pkg::ByteW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] FullCount = AW'(BUFFER_DEPTH - 1);

  dfr_pkg::dfr_state_e state_q, state_d;

  logic [dfr_pkg::ByteW-1:0] start_char_q, end_char_q;
  logic [AW-1:0] count_q, count_d;   // bytes held
  logic [AW-1:0] len_q, len_d;       // length of frame playing out
  logic [AW-1:0] rd_ptr_q, rd_ptr_d; // index of byte on msg

  logic in_acc, out_acc, is_end, is_start, last;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [dfr_pkg::ByteW-1:0] mem_rdata;

  assign in_stall_o  = (state_q != dfr_pkg::StIdle);
  assign out_valid_o = (state_q == dfr_pkg::StSend);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // end wins when a byte matches both delimiters
  assign is_end   = (rx_byte_i == end_char_q);
  assign is_start = (rx_byte_i == start_char_q) && !is_end;
  assign last     = (rd_ptr_q == len_q - AW'(1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    len_d     = len_q;
    rd_ptr_d  = rd_ptr_q;
    mem_we    = 1'b0;
    mem_waddr = count_q;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q + AW'(1);

    unique case (state_q)
      dfr_pkg::StIdle: begin
        if (in_acc) begin
          if (is_end) begin
            if (count_q != '0) begin
              // fetch byte zero, the frame length is latched and count freed
              mem_re    = 1'b1;
              mem_raddr = '0;
              len_d     = count_q;
              rd_ptr_d  = '0;
              count_d   = '0;
              state_d   = dfr_pkg::StSend;
            end
          end else if (is_start) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_d   = AW'(1);
          end else if (count_q != FullCount) begin
            mem_we  = 1'b1;
            count_d = count_q + AW'(1);
          end else begin
            // overflow: reject frame, drop byte
            count_d = '0;
          end
        end
      end
      dfr_pkg::StSend: begin
        if (out_acc) begin
          if (last) begin
            state_d = dfr_pkg::StIdle;
          end else begin
            mem_re   = 1'b1;
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
      end
      default: state_d = dfr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dfr_pkg::StIdle;
      count_q      <= '0;
      start_char_q <= dfr_pkg::StartCharRst;
      end_char_q   <= dfr_pkg::EndCharRst;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dfr_pkg::RegStartChar: start_char_q <= cfg_wdata_i;
          dfr_pkg::RegEndChar:   end_char_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    rd_ptr_q <= rd_ptr_d;
  end

  dfr_frame_mem #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(rx_byte_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign msg_byte_o   = mem_rdata;
  assign msg_last_o   = last;
  assign msg_length_o = dfr_pkg::LenW'(len_q);

endmodule

[sim/delimited_frame_receiver_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver_tb
// Self-checking bench for the delimited frame receiver. A negedge driver
// feeds received bytes from a queue, and a posedge monitor mirrors the frame
// store to predict every released message byte and checks each msg request
// field by field. Both sides idle at random. One long msg hold-off backs up
// the rx side. The start and end characters move through several settings
// between phases.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_tb;

  localparam int unsigned FrameDepth = 64;
  localparam int unsigned QuietCycles = 4;   // lets a last start/data byte settle in the store

  typedef logic [dfr_pkg::ByteW-1:0] byte_t;

  // one released message byte as the msg channel should show it
  typedef struct packed {
    byte_t                     data;
    logic                      last;
    logic [dfr_pkg::LenW-1:0]  len;
  } msg_rec_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;

  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  byte_t  rx_byte_i = '0;

  logic                      out_valid_o;
  logic                      out_stall_i = 1'b1;
  byte_t                     msg_byte_o;
  logic                      msg_last_o;
  logic [dfr_pkg::LenW-1:0]  msg_length_o;

  logic   cfg_we_i = 1'b0;
  logic   cfg_index_i = dfr_pkg::RegStartChar;
  byte_t  cfg_wdata_i = '0;

  delimited_frame_receiver #(
    .BUFFER_DEPTH (FrameDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .msg_byte_o   (msg_byte_o),
    .msg_last_o   (msg_last_o),
    .msg_length_o (msg_length_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Mirror of the block: frame store, fill count and the two delimiters.
  // --------------------------------------------------------------------------
  byte_t     frame_mirror [FrameDepth];
  int        fill_mirror = 0;
  byte_t     start_char_m = dfr_pkg::StartCharRst;
  byte_t     end_char_m   = dfr_pkg::EndCharRst;

  msg_rec_t  released_q [$];     // message bytes still owed by the block
  byte_t     rx_pending_q [$];   // bytes not yet offered on rx

  int        n_queued = 0;       // rx requests put in rx_pending_q
  int        n_taken = 0;        // rx requests accepted by the block
  int        n_fail = 0;

  // Handshake notes passed from the posedge monitor to the negedge drivers.
  bit        rx_taken = 1'b0;
  bit        msg_taken = 1'b0;

  // Long hold-off on the msg side, armed by the stimulus, counted down below.
  int        msg_hold_left = 0;

  // One accepted rx byte: an end char releases the held frame, a start char
  // restarts it, anything else is appended until the store holds depth-1.
  // A byte equal to both delimiters counts as an end char.
  task automatic collect_byte(input byte_t b);
    msg_rec_t rec;
    if (b == end_char_m) begin
      if (fill_mirror != 0) begin
        for (int k = 0; k < fill_mirror; k++) begin
          rec.data = frame_mirror[k];
          rec.last = (k + 1 == fill_mirror);
          rec.len  = fill_mirror[dfr_pkg::LenW-1:0];
          released_q.push_back(rec);
        end
        fill_mirror = 0;
      end
    end else begin
      if (b == start_char_m) fill_mirror = 0;
      if (fill_mirror < FrameDepth - 1) begin
        frame_mirror[fill_mirror] = b;
        fill_mirror++;
      end else begin
        // store full: frame rejected, byte dropped
        fill_mirror = 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_ports
    msg_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        msg_taken = 1'b1;
        if (released_q.size() == 0) begin
          $error("msg request with nothing owed: msg_byte %0h", msg_byte_o);
          n_fail++;
        end else begin
          want = released_q.pop_front();
          if (msg_byte_o !== want.data) begin
            $error("msg_byte: expected %0h, got %0h", want.data, msg_byte_o);
            n_fail++;
          end
          if (msg_last_o !== want.last) begin
            $error("msg_last: expected %0b, got %0b", want.last, msg_last_o);
            n_fail++;
          end
          if (msg_length_o !== want.len) begin
            $error("msg_length: expected %0d, got %0d", want.len, msg_length_o);
            n_fail++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        rx_taken = 1'b1;
        n_taken++;
        collect_byte(rx_byte_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // rx driver: one byte per request, a random gap after each, with calm
  // stretches that send back to back. A stalled byte is held as is.
  // --------------------------------------------------------------------------
  int  tx_wait = 0;
  bit  tx_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !rx_taken) begin
        // still waiting on the block
      end else begin
        rx_taken = 1'b0;
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (rx_pending_q.size() > 0) begin
          rx_byte_i  <= rx_pending_q.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
          tx_wait = tx_calm ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // msg side stall: a fresh wait after every taken msg request, calm
  // stretches with none, and the long hold-off when armed.
  // --------------------------------------------------------------------------
  int  rx_wait = 0;
  bit  rx_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (msg_hold_left > 0) begin
        msg_hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (msg_taken) begin
          msg_taken = 1'b0;
          if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
          rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
        end
        if (rx_wait > 0) begin
          rx_wait--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input byte_t b);
    rx_pending_q.push_back(b);
    n_queued++;
  endtask

  // random byte that is neither delimiter
  function automatic byte_t body_byte();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255));
    while (b == start_char_m || b == end_char_m);
    return b;
  endfunction

  task automatic queue_frame(input int body_len, input bit lead, input bit tail);
    if (lead) queue_byte(start_char_m);
    repeat (body_len) queue_byte(body_byte());
    if (tail) queue_byte(end_char_m);
  endtask

  // Mostly well-formed frames with random content; the rest are frames
  // missing a delimiter and raw noise that may hit either delimiter.
  task automatic queue_traffic(input int n_items);
    int first;
    int kind;
    int body;
    first = n_queued;
    while (n_queued - first < n_items) begin
      kind = $urandom_range(0, 9);
      body = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 64) : $urandom_range(0, 10);
      if (kind < 7) queue_frame(body, 1'b1, 1'b1);
      else if (kind == 7) queue_frame(body, 1'b0, 1'b1);
      else if (kind == 8) queue_frame(body, 1'b1, 1'b0);
      else repeat ($urandom_range(1, 4)) queue_byte(byte_t'($urandom_range(0, 255)));
    end
  endtask

  // All bytes accepted and every owed message byte seen, then QuietCycles more
  // negedges so a last start or data byte is surely written into the store.
  task automatic wait_quiet();
    while (n_taken != n_queued || released_q.size() != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  // Register write; only called with the block idle.
  task automatic write_char_reg(input logic idx, input byte_t val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dfr_pkg::RegStartChar) start_char_m = val;
    else end_char_m = val;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_phases
    byte_t shared;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset delimiters '#' and CR.
    queue_byte(end_char_m);                       // end with empty store
    queue_byte(start_char_m);                     // field extremes
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(end_char_m);
    queue_frame(0, 1'b1, 1'b1);                   // start then end: one byte
    queue_byte(8'h41);                            // frame with no start char
    queue_byte(8'hBE);
    queue_byte(end_char_m);
    queue_byte(start_char_m);                     // restart mid-frame
    queue_byte(8'h55);
    queue_byte(start_char_m);
    queue_byte(8'hAA);
    queue_byte(end_char_m);
    queue_byte(end_char_m);                       // back to back ends
    queue_byte(end_char_m);
    wait_quiet();

    // Full store with the msg side held off so rx backs up during playout.
    // The hold outlasts the slowest delivery of the first frame's end byte.
    @(posedge clk_i);
    msg_hold_left = 1500;
    queue_frame(62, 1'b1, 1'b1);                  // longest frame, length 63
    queue_frame(5, 1'b1, 1'b1);
    queue_frame(3, 1'b1, 1'b1);
    wait_quiet();
    queue_frame(63, 1'b1, 1'b1);                  // overflow: byte dropped, end on empty
    queue_frame(62, 1'b1, 1'b0);                  // store full, then a start char
    queue_frame(2, 1'b1, 1'b1);
    wait_quiet();

    queue_traffic(20);
    wait_quiet();

    write_char_reg(dfr_pkg::RegStartChar, 8'h00);
    write_char_reg(dfr_pkg::RegEndChar, 8'hFF);
    queue_traffic(16);
    wait_quiet();

    write_char_reg(dfr_pkg::RegStartChar, 8'hFF);
    write_char_reg(dfr_pkg::RegEndChar, 8'h00);
    queue_traffic(16);
    wait_quiet();

    // same byte for both delimiters: it always acts as the end char
    shared = byte_t'($urandom_range(0, 255));
    write_char_reg(dfr_pkg::RegStartChar, shared);
    write_char_reg(dfr_pkg::RegEndChar, shared);
    queue_traffic(12);
    wait_quiet();

    write_char_reg(dfr_pkg::RegStartChar, byte_t'($urandom_range(0, 255)));
    write_char_reg(dfr_pkg::RegEndChar, byte_t'($urandom_range(0, 255)));
    queue_traffic(16);
    wait_quiet();

    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
